[sv/gbn_pkg.sv]
// Types, codes and constants shared by the Go-Back-N sender window block.
// No dependencies.
package gbn_pkg;

   localparam int WIN_SLOTS   = 8;
   localparam int SEQ_SPACE   = 16;
   localparam int BACKLOG_MAX = 256;

   localparam int SEQ_W   = $clog2(SEQ_SPACE);
   localparam int SLOT_W  = $clog2(WIN_SLOTS);
   localparam int FLIGHT_W = $clog2(WIN_SLOTS + 1);
   localparam int BACKLOG_W = $clog2(BACKLOG_MAX + 1);
   localparam int TIME_W  = 32;
   localparam int TMO_W   = 16;
   localparam int WIN_W   = 4;

   localparam logic [1:0] KIND_NEW  = 2'd0;
   localparam logic [1:0] KIND_ACK  = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;

   localparam logic [1:0] ACT_SEND    = 2'd0;
   localparam logic [1:0] ACT_RESEND  = 2'd1;
   localparam logic [1:0] ACT_QUEUED  = 2'd2;
   localparam logic [1:0] ACT_REFUSED = 2'd3;

   localparam logic REG_TIMEOUT = 1'b0;
   localparam logic REG_WINDOW  = 1'b1;

   localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd300;
   localparam logic [WIN_W-1:0] WINDOW_RESET  = 4'd8;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] ack_seq;
      logic       ack_ok;
   } req_type;

   typedef struct packed {
      logic [1:0] action;
      logic [3:0] seq;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic new_emit;
      logic ack_free;
      logic tick_inc;
      logic drain_emit;
      logic resend_start;
      logic resend_emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       ack_ok;
      logic       out_free;
      logic       drain_more;
      logic       timeout_hit;
      logic       resend_last;
   } sts_type;

   function automatic logic [FLIGHT_W-1:0] limit_of(input logic [WIN_W-1:0] w);
      logic [FLIGHT_W-1:0] r;
      if (w == '0) begin
         r = FLIGHT_W'(1);
      end else if (int'(w) > WIN_SLOTS) begin
         r = FLIGHT_W'(WIN_SLOTS);
      end else begin
         r = FLIGHT_W'(w);
      end
      return r;
   endfunction

endpackage

[sv/go_back_n_sender_window_core.sv]
// Go-Back-N sender window core: configuration, controller and datapath.
// A new-packet request is decoded in ST_DECODE after acceptance; its result is then
// registered, raising rsp_valid, once the output register is free. A new packet gives
// one result, a rejected ack or unused kind none; an accepted ack drains queued sends and
// a tick may resend all in flight, one result per cycle from the FSM while output is free.
// Reset: synchronous, active high; clears counters and FSM, registers to 300 and 8.
module go_back_n_sender_window_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gbn_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output gbn_pkg::rsp_type     rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   logic [gbn_pkg::TMO_W-1:0] timeout_ticks;
   logic [gbn_pkg::WIN_W-1:0] window_limit;
   gbn_pkg::cmd_type          cmd;
   gbn_pkg::sts_type          sts;

   gbn_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .timeout_ticks (timeout_ticks),
      .window_limit  (window_limit)
   );

   gbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gbn_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_data      (req_data),
      .timeout_ticks (timeout_ticks),
      .window_limit  (window_limit),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

endmodule

[sv/gbn_csr.sv]
// Configuration registers (timeout, window limit) behind an APB-style port.
// Depends on gbn_pkg.
module gbn_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output logic [gbn_pkg::TMO_W-1:0]     timeout_ticks,
   output logic [gbn_pkg::WIN_W-1:0]     window_limit
);

   logic [gbn_pkg::TMO_W-1:0] timeout_ff, timeout_in;
   logic [gbn_pkg::WIN_W-1:0] window_ff, window_in;
   logic                      wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      timeout_in = timeout_ff;
      window_in  = window_ff;
      if (wr_en) begin
         case (paddr[2])
            gbn_pkg::REG_TIMEOUT: timeout_in = pwdata[gbn_pkg::TMO_W-1:0];
            gbn_pkg::REG_WINDOW:  window_in  = pwdata[gbn_pkg::WIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         gbn_pkg::REG_TIMEOUT: prdata = {16'd0, timeout_ff};
         gbn_pkg::REG_WINDOW:  prdata = {28'd0, window_ff};
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= gbn_pkg::TIMEOUT_RESET;
         window_ff  <= gbn_pkg::WINDOW_RESET;
      end else begin
         timeout_ff <= timeout_in;
         window_ff  <= window_in;
      end
   end

   assign timeout_ticks = timeout_ff;
   assign window_limit  = window_ff;

endmodule

[sv/gbn_dp.sv]
// Datapath: sequence and window counters, send-time slots, result register.
// Depends on gbn_pkg; driven by gbn_ctrl commands.
module gbn_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  gbn_pkg::cmd_type              cmd,
   output gbn_pkg::sts_type              sts,
   input  gbn_pkg::req_type              req_data,
   input  logic [gbn_pkg::TMO_W-1:0]     timeout_ticks,
   input  logic [gbn_pkg::WIN_W-1:0]     window_limit,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output gbn_pkg::rsp_type              rsp_data
);

   localparam int SEQ_W     = gbn_pkg::SEQ_W;
   localparam int SLOT_W    = gbn_pkg::SLOT_W;
   localparam int FLIGHT_W  = gbn_pkg::FLIGHT_W;
   localparam int BACKLOG_W = gbn_pkg::BACKLOG_W;
   localparam int TIME_W    = gbn_pkg::TIME_W;

   gbn_pkg::req_type       req_ff, req_in;
   logic [SEQ_W-1:0]       new_seq_ff, new_seq_in;
   logic [SEQ_W-1:0]       base_seq_ff, base_seq_in;
   logic [FLIGHT_W-1:0]    in_flight_ff, in_flight_in;
   logic [BACKLOG_W-1:0]   backlog_ff, backlog_in;
   logic [TIME_W-1:0]      now_ff, now_in;
   logic [SLOT_W-1:0]      head_ff, head_in;
   logic [SLOT_W-1:0]      idx_ff, idx_in;
   logic [TIME_W-1:0]      slot_ff [gbn_pkg::WIN_SLOTS];
   logic                   rsp_valid_ff, rsp_valid_in;
   gbn_pkg::rsp_type       rsp_ff, rsp_in;

   logic [FLIGHT_W-1:0]    lim;
   logic [SEQ_W-1:0]       ack_dist;
   logic [FLIGHT_W-1:0]    freed;
   logic [TIME_W-1:0]      age;
   logic                   slot_we;
   logic [SLOT_W-1:0]      slot_wa;
   logic                   emit;
   logic                   backlog_full;
   logic                   can_send;

   assign lim          = gbn_pkg::limit_of(window_limit);
   assign ack_dist     = req_ff.ack_seq - base_seq_ff;
   assign freed        = FLIGHT_W'(ack_dist) + FLIGHT_W'(1);
   assign age          = now_ff - slot_ff[head_ff];
   assign backlog_full = backlog_ff >= BACKLOG_W'(gbn_pkg::BACKLOG_MAX);
   assign can_send     = (backlog_ff == '0) && (in_flight_ff < lim);
   assign emit         = cmd.new_emit || cmd.drain_emit || cmd.resend_emit;

   assign sts.kind        = req_ff.kind;
   assign sts.ack_ok      = req_ff.ack_ok;
   assign sts.out_free    = !rsp_valid_ff || rsp_ready;
   assign sts.drain_more  = (backlog_ff != '0) && (in_flight_ff < lim);
   assign sts.timeout_hit = (in_flight_ff != '0) && (age >= {16'd0, timeout_ticks});
   assign sts.resend_last = (FLIGHT_W'(idx_ff) + FLIGHT_W'(1)) == in_flight_ff;

   always_comb begin
      req_in       = req_ff;
      new_seq_in   = new_seq_ff;
      base_seq_in  = base_seq_ff;
      in_flight_in = in_flight_ff;
      backlog_in   = backlog_ff;
      now_in       = now_ff;
      head_in      = head_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      slot_we      = 1'b0;
      slot_wa      = head_ff + in_flight_ff[SLOT_W-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.capture) begin
         req_in = req_data;
      end

      if (cmd.new_emit) begin
         rsp_in.seq  = new_seq_ff;
         rsp_in.last = 1'b1;
         if (backlog_full) begin
            rsp_in.action = gbn_pkg::ACT_REFUSED;
         end else begin
            new_seq_in = new_seq_ff + SEQ_W'(1);
            if (can_send) begin
               rsp_in.action = gbn_pkg::ACT_SEND;
               slot_we       = 1'b1;
               in_flight_in  = in_flight_ff + FLIGHT_W'(1);
            end else begin
               rsp_in.action = gbn_pkg::ACT_QUEUED;
               backlog_in    = backlog_ff + BACKLOG_W'(1);
            end
         end
      end

      if (cmd.ack_free && (FLIGHT_W'(ack_dist) < in_flight_ff)) begin
         base_seq_in  = base_seq_ff + freed[SEQ_W-1:0];
         head_in      = head_ff + freed[SLOT_W-1:0];
         in_flight_in = in_flight_ff - freed;
      end

      if (cmd.drain_emit) begin
         rsp_in.action = gbn_pkg::ACT_SEND;
         rsp_in.seq    = base_seq_ff + SEQ_W'(in_flight_ff);
         rsp_in.last   = (backlog_ff == BACKLOG_W'(1)) ||
                         ((in_flight_ff + FLIGHT_W'(1)) == lim);
         slot_we       = 1'b1;
         in_flight_in  = in_flight_ff + FLIGHT_W'(1);
         backlog_in    = backlog_ff - BACKLOG_W'(1);
      end

      if (cmd.tick_inc) begin
         now_in = now_ff + TIME_W'(1);
      end

      if (cmd.resend_start) begin
         idx_in = '0;
      end

      if (cmd.resend_emit) begin
         rsp_in.action = gbn_pkg::ACT_RESEND;
         rsp_in.seq    = base_seq_ff + SEQ_W'(idx_ff);
         rsp_in.last   = sts.resend_last;
         slot_we       = 1'b1;
         slot_wa       = head_ff + idx_ff;
         idx_in        = idx_ff + SLOT_W'(1);
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         new_seq_ff   <= '0;
         base_seq_ff  <= '0;
         in_flight_ff <= '0;
         backlog_ff   <= '0;
         now_ff       <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         new_seq_ff   <= new_seq_in;
         base_seq_ff  <= base_seq_in;
         in_flight_ff <= in_flight_in;
         backlog_ff   <= backlog_in;
         now_ff       <= now_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
      if (slot_we) begin
         slot_ff[slot_wa] <= now_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequence bookkeeping: every number handed out is in flight or queued
   a_seq_sum: assert property (@(posedge clock) disable iff (reset)
      new_seq_ff == SEQ_W'(base_seq_ff + SEQ_W'(in_flight_ff) + SEQ_W'(backlog_ff)))
      else $error("new_seq out of step with base, in_flight and backlog");

   a_flight_max: assert property (@(posedge clock) disable iff (reset)
      int'(in_flight_ff) <= gbn_pkg::WIN_SLOTS)
      else $error("in_flight exceeds window slots");

   a_backlog_max: assert property (@(posedge clock) disable iff (reset)
      int'(backlog_ff) <= gbn_pkg::BACKLOG_MAX)
      else $error("backlog exceeds its maximum");

endmodule

[sv/gbn_ctrl.sv]
// Controller state machine: sequences decode, drain and resend bursts.
// Depends on gbn_pkg; commands gbn_dp.
module gbn_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gbn_pkg::sts_type     sts,
   output gbn_pkg::cmd_type     cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECODE = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_CHECK  = 5'b01000,
      ST_RESEND = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.kind)
               gbn_pkg::KIND_NEW: begin
                  if (sts.out_free) begin
                     cmd.new_emit = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               gbn_pkg::KIND_ACK: begin
                  if (sts.ack_ok) begin
                     cmd.ack_free = 1'b1;
                     state_in     = ST_DRAIN;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               gbn_pkg::KIND_TICK: begin
                  cmd.tick_inc = 1'b1;
                  state_in     = ST_CHECK;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_DRAIN: begin
            if (!sts.drain_more) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.drain_emit = 1'b1;
            end
         end
         ST_CHECK: begin
            if (sts.timeout_hit) begin
               cmd.resend_start = 1'b1;
               state_in         = ST_RESEND;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RESEND: begin
            if (sts.out_free) begin
               cmd.resend_emit = 1'b1;
               if (sts.resend_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state not one-hot");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_DECODE)
      else $error("accepted request not decoded next cycle");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.new_emit || cmd.drain_emit || cmd.resend_emit) |-> sts.out_free)
      else $error("result issued while output register busy");

endmodule

[dv/tb_go_back_n_sender_window_core.sv]
// Self-checking testbench for go_back_n_sender_window_core: directed and random requests,
// APB register writes, and a tracker class that predicts each send/resend/queue/refuse result.
// Depends on gbn_pkg and the go_back_n_sender_window_core RTL.
module tb_go_back_n_sender_window_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES = 400;

   class window_tracker;
      logic [gbn_pkg::TMO_W-1:0]  timeout_ticks;
      logic [gbn_pkg::WIN_W-1:0]  window_limit;
      logic [gbn_pkg::SEQ_W-1:0]  new_seq;
      logic [gbn_pkg::SEQ_W-1:0]  base_seq;
      int                         in_flight;
      int                         backlog;
      int                         ring_head;
      logic [gbn_pkg::TIME_W-1:0] now_ticks;
      logic [gbn_pkg::TIME_W-1:0] sent_at [gbn_pkg::WIN_SLOTS];
      gbn_pkg::rsp_type           burst[$];
      gbn_pkg::rsp_type           pending_actions[$];
      int                         mismatch_count;

      function new();
         timeout_ticks = gbn_pkg::TIMEOUT_RESET;
         window_limit = gbn_pkg::WINDOW_RESET;
         new_seq = '0;
         base_seq = '0;
         in_flight = 0;
         backlog = 0;
         ring_head = 0;
         now_ticks = '0;
         mismatch_count = 0;
         foreach (sent_at[i]) sent_at[i] = '0;
      endfunction

      function int window_room();
         if (window_limit == '0) return 1;
         if (int'(window_limit) > gbn_pkg::WIN_SLOTS) return gbn_pkg::WIN_SLOTS;
         return int'(window_limit);
      endfunction

      function void push_action(logic [1:0] action, logic [gbn_pkg::SEQ_W-1:0] seq);
         gbn_pkg::rsp_type a;
         a.action = action;
         a.seq = seq;
         a.last = 1'b0;
         burst = {burst, a};
      endfunction

      function void start_flight();
         sent_at[(ring_head + in_flight) % gbn_pkg::WIN_SLOTS] = now_ticks;
         in_flight++;
      endfunction

      function void drain_backlog();
         while (backlog > 0 && in_flight < window_room()) begin
            push_action(gbn_pkg::ACT_SEND, base_seq + gbn_pkg::SEQ_W'(in_flight));
            start_flight();
            backlog--;
         end
      endfunction

      function void take_request(gbn_pkg::req_type r);
         logic [gbn_pkg::SEQ_W-1:0]  ack_gap;
         logic [gbn_pkg::TIME_W-1:0] age;
         burst.delete();
         case (r.kind)
            gbn_pkg::KIND_NEW: begin
               if (backlog >= gbn_pkg::BACKLOG_MAX) begin
                  push_action(gbn_pkg::ACT_REFUSED, new_seq);
               end else begin
                  if (backlog == 0 && in_flight < window_room()) begin
                     push_action(gbn_pkg::ACT_SEND, new_seq);
                     start_flight();
                  end else begin
                     backlog++;
                     push_action(gbn_pkg::ACT_QUEUED, new_seq);
                  end
                  new_seq = new_seq + 1'b1;
               end
            end
            gbn_pkg::KIND_ACK: begin
               if (r.ack_ok) begin
                  ack_gap = r.ack_seq - base_seq;
                  if (int'(ack_gap) < in_flight) begin
                     base_seq = base_seq + ack_gap + 1'b1;
                     ring_head = (ring_head + int'(ack_gap) + 1) % gbn_pkg::WIN_SLOTS;
                     in_flight -= int'(ack_gap) + 1;
                  end
                  drain_backlog();
               end
            end
            gbn_pkg::KIND_TICK: begin
               now_ticks = now_ticks + 1'b1;
               if (in_flight > 0) begin
                  age = now_ticks - sent_at[ring_head];
                  if (age >= gbn_pkg::TIME_W'(timeout_ticks)) begin
                     for (int i = 0; i < in_flight; i++) begin
                        sent_at[(ring_head + i) % gbn_pkg::WIN_SLOTS] = now_ticks;
                        push_action(gbn_pkg::ACT_RESEND, base_seq + gbn_pkg::SEQ_W'(i));
                     end
                  end
               end
            end
            default: ;
         endcase
         if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
         pending_actions = {pending_actions, burst};
      endfunction

      function void check_field(string name, int want, int got);
         if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatch_count++;
         end
      endfunction

      function void match_result(gbn_pkg::rsp_type got);
         gbn_pkg::rsp_type want;
         if (pending_actions.size() == 0) begin
            $error("unexpected response: action %0d seq %0d last %0d",
                   got.action, got.seq, got.last);
            mismatch_count++;
            return;
         end
         want = pending_actions.pop_front();
         check_field("action", want.action, got.action);
         check_field("seq", want.seq, got.seq);
         check_field("last", want.last, got.last);
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   gbn_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   gbn_pkg::rsp_type rsp_data;
   logic             psel = 1'b0;
   logic             penable = 1'b0;
   logic             pwrite = 1'b0;
   logic [2:0]       paddr = '0;
   logic [31:0]      pwdata = '0;
   logic [31:0]      prdata;
   logic             pready;

   window_tracker tracker;
   logic  steady = 1'b0;
   int    hold_requests = 0;
   int    holds_served = 0;
   int    hold_left = 0;
   int    cycle_count = 0;

   go_back_n_sender_window_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 14);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.match_result(rsp_data);
   end

   task automatic send_request(logic [1:0] kind, logic [gbn_pkg::SEQ_W-1:0] ack_seq,
                               logic ack_ok);
      gbn_pkg::req_type r;
      int               gap;
      r.kind = kind;
      r.ack_seq = ack_seq;
      r.ack_ok = ack_ok;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.take_request(r);
      gap = 0;
      if (!steady) begin
         while ($urandom_range(99) < 14) gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic random_request();
      int                        pick;
      logic [gbn_pkg::SEQ_W-1:0] ack_seq;
      pick = $urandom_range(99);
      if (pick < 38) begin
         send_request(gbn_pkg::KIND_NEW, gbn_pkg::SEQ_W'($urandom), 1'($urandom));
      end else if (pick < 68) begin
         if (tracker.in_flight > 0 && $urandom_range(4) != 0)
            ack_seq = tracker.base_seq +
                      gbn_pkg::SEQ_W'($urandom_range(tracker.in_flight - 1));
         else
            ack_seq = gbn_pkg::SEQ_W'($urandom);
         send_request(gbn_pkg::KIND_ACK, ack_seq, $urandom_range(9) != 0);
      end else if (pick < 95) begin
         send_request(gbn_pkg::KIND_TICK, gbn_pkg::SEQ_W'($urandom), 1'($urandom));
      end else begin
         send_request(KIND_NONE, gbn_pkg::SEQ_W'($urandom), 1'($urandom));
      end
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_actions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic reg_sel, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_sel, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (reg_sel == gbn_pkg::REG_TIMEOUT) tracker.timeout_ticks = value[gbn_pkg::TMO_W-1:0];
      else tracker.window_limit = value[gbn_pkg::WIN_W-1:0];
      @(posedge clock);
   endtask

   task automatic reconfigure(int timeout_val, int window_val);
      settle_block();
      csr_write(gbn_pkg::REG_TIMEOUT, 32'(timeout_val));
      csr_write(gbn_pkg::REG_WINDOW, 32'(window_val));
   endtask

   // cumulative acks until nothing is in flight or queued
   task automatic flush_window();
      while (tracker.backlog > 0 || tracker.in_flight > 0)
         send_request(gbn_pkg::KIND_ACK,
                      tracker.base_seq + gbn_pkg::SEQ_W'(tracker.in_flight) - 1'b1, 1'b1);
   endtask

   initial begin
      int timeouts[6];
      int windows[6];
      timeouts = '{5, 0, 65535, 1, 12, 2};
      windows = '{3, 0, 15, 8, 5, 2};
      tracker = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: rejected ack, empty-window ack and tick, unused kind, window fill
      send_request(gbn_pkg::KIND_ACK, 4'd15, 1'b0);
      send_request(gbn_pkg::KIND_ACK, 4'd0, 1'b1);
      send_request(gbn_pkg::KIND_TICK, 4'd0, 1'b0);
      send_request(KIND_NONE, 4'd15, 1'b1);
      repeat (9) send_request(gbn_pkg::KIND_NEW, 4'd0, 1'b0);
      send_request(gbn_pkg::KIND_NEW, 4'd15, 1'b1);
      send_request(gbn_pkg::KIND_ACK, 4'd12, 1'b1);
      send_request(gbn_pkg::KIND_ACK, 4'd3, 1'b0);
      send_request(gbn_pkg::KIND_ACK, 4'd1, 1'b1);
      send_request(gbn_pkg::KIND_ACK, 4'd15, 1'b1);
      send_request(gbn_pkg::KIND_TICK, 4'd15, 1'b1);
      flush_window();

      // backlog overflow with window of one, long output hold-off, no idling
      reconfigure(65535, 1);
      steady <= 1'b1;
      hold_requests <= hold_requests + 1;
      repeat (gbn_pkg::BACKLOG_MAX + 4)
         send_request(gbn_pkg::KIND_NEW, gbn_pkg::SEQ_W'($urandom), 1'($urandom));
      settle_block();
      steady <= 1'b0;

      for (int p = 0; p < 6; p++) begin
         reconfigure(timeouts[p], windows[p]);
         repeat (4) random_request();
      end

      settle_block();
      if (tracker.pending_actions.size() != 0) begin
         $error("%0d expected responses never arrived", tracker.pending_actions.size());
         tracker.mismatch_count++;
      end
      if (tracker.mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
